>>> design/assert_macros.svh
// assertion macros used by the top level design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent in a cycle implies consequent in the next
`define ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// antecedent implies consequent at a later clock edge
`define ASSERT_AFTER2(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
        else $error(msg);

`else

`define ASSERT_ALWAYS(name, clk, rst_n, prop, msg)
`define ASSERT_NEXT(name, clk, rst_n, ante, cons, msg)
`define ASSERT_AFTER2(name, clk, rst_n, ante, cons, msg)

`endif

`endif

>>> design/edd_pkg.sv
// types, opcodes and helpers of the edit distance engine
`default_nettype none

package edd_pkg;

    // default longest string per side
    localparam int MAX_LEN_DEF = 64;

    // command opcodes
    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_LEFT   = 2'd1;
    localparam logic [1:0] OP_RIGHT  = 2'd2;
    localparam logic [1:0] OP_FINISH = 2'd3;

    // command word
    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] char_code;
    } cmd_t;

    // result word
    typedef struct packed {
        logic [6:0] distance;
        logic       overflow;
    } result_t;

    // finish report from the sequencer
    typedef struct packed {
        logic       fin;
        logic [6:0] distance;
        logic       overflow;
    } fin_t;

    // ascii upper case to lower case when folding is on
    function automatic logic [7:0] fold_char(input logic ic, input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (ic && (c >= 8'h41) && (c <= 8'h5A))
        begin
            r = c + 8'h20;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> design/edd_step_unit.sv
// shared compare and minimum unit for one column cell update
`default_nettype none

module edd_step_unit #(
    parameter int DW = 7
) (
    input  wire logic          ignore_case,
    input  wire logic [7:0]    left_char,
    input  wire logic [7:0]    right_char,
    input  wire logic [DW-1:0] diag,
    input  wire logic [DW-1:0] above,
    input  wire logic [DW-1:0] prev,
    output logic      [DW-1:0] new_val
);

    logic          match;
    logic [DW-1:0] min_ap;
    logic [DW-1:0] min_all;

    // folded character compare
    assign match = (edd_pkg::fold_char(ignore_case, left_char) ==
                    edd_pkg::fold_char(ignore_case, right_char));

    // minimum of the three neighbors
    assign min_ap  = (above < prev) ? above : prev;
    assign min_all = (min_ap < diag) ? min_ap : diag;

    // match keeps the diagonal, else one edit more than the best neighbor
    assign new_val = match ? diag : (min_all + DW'(1));

endmodule

`default_nettype wire

>>> design/edd_seq.sv
// sequencer, string store and column store of the edit distance engine
`default_nettype none

module edd_seq #(
    parameter int MAX_LEN = edd_pkg::MAX_LEN_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire edd_pkg::cmd_t cmd,
    input  wire logic          ignore_case,
    output logic               busy,
    output edd_pkg::fin_t      fin
);

    localparam int LW = $clog2(MAX_LEN + 1);
    localparam int DW = LW;
    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int XW = (DW > 7) ? DW : 7;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_STEP = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0]    state_reg, state_next;
    logic [LW-1:0] left_len_reg, left_len_next;
    logic [LW-1:0] right_len_reg, right_len_next;
    logic          ovf_reg, ovf_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [DW-1:0] diag_reg, diag_next;
    logic [DW-1:0] prev_reg, prev_next;
    logic [7:0]    rc_reg, rc_next;

    logic [7:0]    ls_mem [MAX_LEN];
    logic [DW-1:0] dp_mem [MAX_LEN];
    logic [7:0]    ls_q;
    logic [DW-1:0] dp_q;

    logic          accept;
    logic [AW-1:0] rd_addr;
    logic          ls_we;
    logic          dp_we;
    logic [LW-1:0] left_m1;
    logic [AW-1:0] last_idx;
    logic [DW-1:0] above;
    logic [DW-1:0] new_val;
    logic [DW-1:0] dist_full;
    logic [XW-1:0] dist_ext;

    assign busy     = (state_reg != ST_IDLE);
    assign accept   = start && !busy;
    assign left_m1  = left_len_reg - LW'(1);
    assign last_idx = left_m1[AW-1:0];

    // column entries read as their row index until the first right word
    assign above = (right_len_reg == '0) ? (DW'(idx_reg) + DW'(1)) : dp_q;

    // read address: first cell for a right word, else last cell; next cell while walking
    always_comb
    begin
        case (state_reg)
            ST_STEP:
            begin
                rd_addr = idx_reg + AW'(1);
            end
            default:
            begin
                rd_addr = (cmd.opcode == edd_pkg::OP_RIGHT) ? '0 : last_idx;
            end
        endcase
    end

    // compare and minimum unit
    edd_step_unit #(
        .DW (DW)
    ) u_step (
        .ignore_case (ignore_case),
        .left_char   (ls_q),
        .right_char  (rc_reg),
        .diag        (diag_reg),
        .above       (above),
        .prev        (prev_reg),
        .new_val     (new_val)
    );

    // sequencer next state
    always_comb
    begin
        state_next     = state_reg;
        left_len_next  = left_len_reg;
        right_len_next = right_len_reg;
        ovf_next       = ovf_reg;
        idx_next       = idx_reg;
        diag_next      = diag_reg;
        prev_next      = prev_reg;
        rc_next        = rc_reg;
        ls_we          = 1'b0;
        dp_we          = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (cmd.opcode)
                        edd_pkg::OP_CLEAR:
                        begin
                            left_len_next  = '0;
                            right_len_next = '0;
                            ovf_next       = 1'b0;
                        end
                        edd_pkg::OP_LEFT:
                        begin
                            if (right_len_reg == '0)
                            begin
                                if (left_len_reg == LW'(MAX_LEN))
                                begin
                                    ovf_next = 1'b1;
                                end
                                else
                                begin
                                    ls_we         = 1'b1;
                                    left_len_next = left_len_reg + LW'(1);
                                end
                            end
                        end
                        edd_pkg::OP_RIGHT:
                        begin
                            if (right_len_reg == LW'(MAX_LEN))
                            begin
                                ovf_next = 1'b1;
                            end
                            else
                            begin
                                rc_next   = cmd.char_code;
                                diag_next = right_len_reg;
                                prev_next = right_len_reg + LW'(1);
                                idx_next  = '0;
                                if (left_len_reg == '0)
                                begin
                                    right_len_next = right_len_reg + LW'(1);
                                end
                                else
                                begin
                                    state_next = ST_STEP;
                                end
                            end
                        end
                        default:
                        begin
                            state_next = ST_FIN;
                        end
                    endcase
                end
            end
            ST_STEP:
            begin
                dp_we     = 1'b1;
                diag_next = above;
                prev_next = new_val;
                idx_next  = idx_reg + AW'(1);
                if (idx_reg == last_idx)
                begin
                    right_len_next = right_len_reg + LW'(1);
                    state_next     = ST_IDLE;
                end
            end
            ST_FIN:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            left_len_reg  <= '0;
            right_len_reg <= '0;
            ovf_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            left_len_reg  <= left_len_next;
            right_len_reg <= right_len_next;
            ovf_reg       <= ovf_next;
        end
    end

    // working registers of the column walk
    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        diag_reg <= diag_next;
        prev_reg <= prev_next;
        rc_reg   <= rc_next;
    end

    // left string store, registered read
    always_ff @(posedge clk)
    begin
        if (ls_we)
        begin
            ls_mem[left_len_reg[AW-1:0]] <= cmd.char_code;
        end
        ls_q <= ls_mem[rd_addr];
    end

    // column store for rows one and up, registered read
    always_ff @(posedge clk)
    begin
        if (dp_we)
        begin
            dp_mem[idx_reg] <= new_val;
        end
        dp_q <= dp_mem[rd_addr];
    end

    // distance at the left length; row zero equals the right length, column zero the left length
    always_comb
    begin
        if (left_len_reg == '0)
        begin
            dist_full = right_len_reg;
        end
        else if (right_len_reg == '0)
        begin
            dist_full = left_len_reg;
        end
        else
        begin
            dist_full = dp_q;
        end
    end

    assign dist_ext     = XW'(dist_full);
    assign fin.fin      = (state_reg == ST_FIN);
    assign fin.distance = dist_ext[6:0];
    assign fin.overflow = ovf_reg;

endmodule

`default_nettype wire

>>> design/edit_distance_engine.sv
// top level of the edit distance engine
//
//  channel   signals                        direction  handshake
//  command   start, busy, cmd               in         taken when start and not busy
//  result    done, result                   out        one cycle strobe, no back pressure
//  config    cfg_we, cfg_data               in         written when cfg_we is high
//
// clear and left append words leave busy low; a finish word keeps busy high
// in the cycle after it is taken, while the sequencer is in its finish state.
// a right word keeps busy high while the single compare and minimum unit walks
// the stored left characters, up to MAX_LEN, one cell a cycle.
// done registers the finish state of a finish word; its word is accepted at
// the next edge. reset needs no clearing pass: column cells read as their row
// index until the first right word after a clear. done cannot be stalled.
`default_nettype none

`include "assert_macros.svh"

module edit_distance_engine #(
    parameter int MAX_LEN = edd_pkg::MAX_LEN_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire edd_pkg::cmd_t    cmd,
    output logic                  done,
    output edd_pkg::result_t      result,
    input  wire logic             cfg_we,
    input  wire logic             cfg_data
);

    logic             ignore_case_reg;
    logic             done_reg;
    edd_pkg::result_t result_reg;
    edd_pkg::fin_t    fin;
    logic             take_finish;
    logic             take_clear;

    // sequencer with stores and shared unit
    edd_seq #(
        .MAX_LEN (MAX_LEN)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .cmd         (cmd),
        .ignore_case (ignore_case_reg),
        .busy        (busy),
        .fin         (fin)
    );

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ignore_case_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            ignore_case_reg <= cfg_data;
        end
    end

    // result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= fin.fin;
        end
    end

    // result word
    always_ff @(posedge clk)
    begin
        if (fin.fin)
        begin
            result_reg.distance <= fin.distance;
            result_reg.overflow <= fin.overflow;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    // finish and clear words taken this cycle
    assign take_finish = start && !busy && (cmd.opcode == edd_pkg::OP_FINISH);
    assign take_clear  = start && !busy && (cmd.opcode == edd_pkg::OP_CLEAR);

    // checks
    `ASSERT_NEXT(a_done_single, clk, rst_n, done, !done, "done held two cycles")
    `ASSERT_ALWAYS(a_done_idle, clk, rst_n, !done || !busy, "done while busy")
    `ASSERT_AFTER2(a_finish_done, clk, rst_n, take_finish, done, "finish without result")
    `ASSERT_NEXT(a_clear_fast, clk, rst_n, take_clear, !busy, "clear left block busy")

endmodule

`default_nettype wire

>>> dv/edit_distance_engine_test.sv
// self-checking testbench of the edit distance engine with a distance scoreboard
`timescale 1ns / 100ps

// predicts the distance column and checks finish results in order
class edit_distance_scoreboard;

    localparam int STR_MAX = edd_pkg::MAX_LEN_DEF;

    logic [7:0]           left_chars [STR_MAX];
    int unsigned          cost_col [STR_MAX + 1];
    int unsigned          left_len;
    int unsigned          right_len;
    bit                   overflow_seen;
    bit                   case_fold;
    edd_pkg::result_t     pending_distances [$];
    int unsigned          failures;
    int unsigned          words_seen;
    int unsigned          results_seen;
    int unsigned          overflow_results;

    function new();
        foreach (left_chars[i])
        begin
            left_chars[i] = 8'h00;
        end
        case_fold = 1'b0;
        failures = 0;
        words_seen = 0;
        results_seen = 0;
        overflow_results = 0;
        restart_pair();
    endfunction

    // new pair: empty strings, column holds the row index
    function void restart_pair();
        left_len = 0;
        right_len = 0;
        overflow_seen = 1'b0;
        for (int i = 0; i <= STR_MAX; i++)
        begin
            cost_col[i] = i;
        end
    endfunction

    function void set_case_fold(bit value);
        case_fold = value;
    endfunction

    // upper case ascii to lower case when folding is on
    function logic [7:0] folded(logic [7:0] c);
        if (case_fold && c >= 8'h41 && c <= 8'h5A)
        begin
            return c + 8'h20;
        end
        return c;
    endfunction

    // one column step for a right character
    function void advance_column(logic [7:0] ch);
        int unsigned diag;
        int unsigned above;
        int unsigned best;
        logic [7:0]  rc;
        if (right_len >= STR_MAX)
        begin
            overflow_seen = 1'b1;
            return;
        end
        rc = folded(ch);
        diag = cost_col[0];
        cost_col[0] = right_len + 1;
        for (int i = 1; i <= left_len; i++)
        begin
            above = cost_col[i];
            if (folded(left_chars[i - 1]) == rc)
            begin
                cost_col[i] = diag;
            end
            else
            begin
                best = above;
                if (cost_col[i - 1] < best)
                begin
                    best = cost_col[i - 1];
                end
                if (diag < best)
                begin
                    best = diag;
                end
                cost_col[i] = best + 1;
            end
            diag = above;
        end
        right_len++;
    endfunction

    // accepted command word
    function void note_word(edd_pkg::cmd_t w);
        edd_pkg::result_t r;
        words_seen++;
        case (w.opcode)
            edd_pkg::OP_CLEAR:
            begin
                restart_pair();
            end
            edd_pkg::OP_LEFT:
            begin
                // left chars after the first right char are dropped silently
                if (right_len == 0)
                begin
                    if (left_len >= STR_MAX)
                    begin
                        overflow_seen = 1'b1;
                    end
                    else
                    begin
                        left_chars[left_len] = w.char_code;
                        left_len++;
                    end
                end
            end
            edd_pkg::OP_RIGHT:
            begin
                advance_column(w.char_code);
            end
            default:
            begin
                r.distance = cost_col[left_len][6:0];
                r.overflow = overflow_seen;
                pending_distances.insert(pending_distances.size(), r);
            end
        endcase
    endfunction

    // result word from the block
    function void check_result(edd_pkg::result_t r);
        edd_pkg::result_t exp_r;
        results_seen++;
        if (r.overflow)
        begin
            overflow_results++;
        end
        if (pending_distances.size() == 0)
        begin
            failures++;
            if (failures <= 10)
            begin
                $display("unexpected result: distance %0d overflow %0d", r.distance, r.overflow);
            end
            return;
        end
        exp_r = pending_distances.pop_front();
        if (r.distance !== exp_r.distance || r.overflow !== exp_r.overflow)
        begin
            failures++;
            if (failures <= 10)
            begin
                $display("mismatch: distance exp %0d got %0d, overflow exp %0d got %0d",
                         exp_r.distance, r.distance, exp_r.overflow, r.overflow);
            end
        end
    endfunction

    function int unsigned pending();
        return pending_distances.size();
    endfunction

endclass

module edit_distance_engine_test;

    localparam int        ITEM_TARGET = 1750;
    localparam int        PHASES = 6;
    localparam int        SETTLE_CYCLES = 80;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    edd_pkg::cmd_t        cmd;
    logic                 done;
    edd_pkg::result_t     result;
    logic                 cfg_we;
    logic                 cfg_data;

    edit_distance_scoreboard sb = new();
    bit                   no_idle;
    int unsigned          long_pairs;

    edit_distance_engine u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .cmd      (cmd),
        .done     (done),
        .result   (result),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // result monitor, done cannot be stalled
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            sb.check_result(result);
        end
    end

    // idle length before a word: mostly none, a few long
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (no_idle)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            return 0;
        end
        if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // character mix: small alphabet in both cases, raw bytes, fold edges
    function automatic logic [7:0] pick_char();
        logic [7:0] edges [10] = '{8'h00, 8'h40, 8'h41, 8'h5A, 8'h5B,
                                   8'h60, 8'h61, 8'h7A, 8'h7B, 8'hFF};
        logic [7:0] c;
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel < 5)
        begin
            c = 8'h61 + 8'($urandom_range(0, 3));
            if ($urandom_range(0, 1))
            begin
                c = c - 8'h20;
            end
        end
        else if (sel < 7)
        begin
            c = 8'($urandom_range(0, 255));
        end
        else
        begin
            c = edges[$urandom_range(0, 9)];
        end
        return c;
    endfunction

    // present one word and hold it until taken
    task automatic send_word(logic [1:0] op, logic [7:0] ch);
        edd_pkg::cmd_t w;
        int unsigned   gap;
        w.opcode = op;
        w.char_code = ch;
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        cmd <= w;
        do
        begin
            @(posedge clk);
        end
        while (busy);
        sb.note_word(w);
    endtask

    // stop sending and wait for every finish result and the last column walk
    task automatic drain();
        start <= 1'b0;
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // case folding register, written only while idle
    task automatic write_case_fold(bit value);
        drain();
        cfg_we <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        sb.set_case_fold(value);
        cfg_we <= 1'b0;
    endtask

    function automatic int unsigned pick_len();
        if ($urandom_range(0, 9) == 0)
        begin
            long_pairs++;
            return $urandom_range(58, 70);
        end
        return $urandom_range(0, 8);
    endfunction

    // one well-formed pair with random content and a few stray words
    task automatic run_pair();
        int unsigned left_n;
        int unsigned right_n;
        left_n = pick_len();
        right_n = pick_len();
        no_idle = ($urandom_range(0, 4) == 0);
        send_word(edd_pkg::OP_CLEAR, pick_char());
        for (int i = 0; i < left_n; i++)
        begin
            send_word(edd_pkg::OP_LEFT, pick_char());
        end
        for (int i = 0; i < right_n; i++)
        begin
            send_word(edd_pkg::OP_RIGHT, pick_char());
            if ($urandom_range(0, 5) == 0)
            begin
                send_word(edd_pkg::OP_FINISH, pick_char());
            end
            if ($urandom_range(0, 24) == 0)
            begin
                send_word(edd_pkg::OP_LEFT, pick_char());
            end
        end
        send_word(edd_pkg::OP_FINISH, pick_char());
        no_idle = 1'b0;
    endtask

    // unordered words with any opcode
    task automatic run_noise();
        int unsigned n;
        n = $urandom_range(4, 12);
        for (int i = 0; i < n; i++)
        begin
            send_word(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
        end
    endtask

    // stimulus
    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        cmd = '0;
        cfg_we = 1'b0;
        cfg_data = 1'b0;
        no_idle = 1'b0;
        long_pairs = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty pair, byte extremes, left after right, finish then more right
        send_word(edd_pkg::OP_FINISH, 8'h00);
        send_word(edd_pkg::OP_CLEAR, 8'h00);
        send_word(edd_pkg::OP_LEFT, 8'h41);
        send_word(edd_pkg::OP_LEFT, 8'hFF);
        send_word(edd_pkg::OP_LEFT, 8'h00);
        send_word(edd_pkg::OP_RIGHT, 8'h61);
        send_word(edd_pkg::OP_RIGHT, 8'hFF);
        send_word(edd_pkg::OP_RIGHT, 8'h00);
        send_word(edd_pkg::OP_FINISH, 8'h00);
        send_word(edd_pkg::OP_LEFT, 8'h7A);
        send_word(edd_pkg::OP_FINISH, 8'hFF);
        send_word(edd_pkg::OP_RIGHT, 8'h5A);
        send_word(edd_pkg::OP_FINISH, 8'h55);
        send_word(edd_pkg::OP_CLEAR, 8'hFF);
        send_word(edd_pkg::OP_FINISH, 8'hAA);

        // directed: folding on, letters against their neighbors
        write_case_fold(1'b1);
        send_word(edd_pkg::OP_CLEAR, 8'h00);
        send_word(edd_pkg::OP_LEFT, 8'h5A);
        send_word(edd_pkg::OP_LEFT, 8'h40);
        send_word(edd_pkg::OP_LEFT, 8'h5B);
        send_word(edd_pkg::OP_RIGHT, 8'h7A);
        send_word(edd_pkg::OP_RIGHT, 8'h40);
        send_word(edd_pkg::OP_RIGHT, 8'h7B);
        send_word(edd_pkg::OP_FINISH, 8'h00);

        // random phases, folding alternates between them
        for (int p = 0; p < PHASES; p++)
        begin
            write_case_fold(p[0]);
            while (sb.words_seen < ITEM_TARGET * (p + 1) / PHASES)
            begin
                if ($urandom_range(0, 7) == 0)
                begin
                    run_noise();
                end
                else
                begin
                    run_pair();
                end
            end
        end

        // wrap up
        drain();
        $display("covered %0d words, %0d results (%0d with overflow), %0d long strings",
                 sb.words_seen, sb.results_seen, sb.overflow_results, long_pairs);
        $display("case folding toggled over %0d random phases", PHASES);
        if (sb.failures == 0 && sb.pending() == 0)
        begin
            $display("edit_distance_engine test passed");
        end
        else
        begin
            $display("edit_distance_engine test failed");
        end
        $finish;
    end

    // watchdog
    initial
    begin
        #10_000_000;
        $display("edit_distance_engine test failed");
        $finish;
    end

endmodule

>>> sim.f
+incdir+design
design/edd_pkg.sv
design/edd_step_unit.sv
design/edd_seq.sv
design/edit_distance_engine.sv
dv/edit_distance_engine_test.sv
